[src/lls_pkg.sv]
// Shared types and constants for the least-loaded peer selector.
package lls_pkg;

  // Field widths fixed by the item format
  localparam int OP_W   = 2;
  localparam int PEER_W = 10;

  // Operation codes carried in op
  localparam logic [OP_W-1:0] OP_OFFER   = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;
  localparam logic [OP_W-1:0] OP_END     = 2'd3;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ACT
  } lls_state_t;

endpackage

[src/lls_table.sv]
// Peer table memory: one write port, one read port with registered data.
module lls_table #(
  parameter int TABLE_DEPTH = 64,
  parameter int LOAD_BITS   = 16
) (
  input  logic                              clk,
  input  logic                              rd_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0]    rd_addr,
  output logic [lls_pkg::PEER_W-1:0]        rd_peer,
  output logic [LOAD_BITS-1:0]              rd_load,
  input  logic                              wr_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0]    wr_addr,
  input  logic [lls_pkg::PEER_W-1:0]        wr_peer,
  input  logic [LOAD_BITS-1:0]              wr_load
);
  import lls_pkg::*;

  localparam int WORD_W = PEER_W + LOAD_BITS;

  logic [WORD_W-1:0] mem [TABLE_DEPTH];
  logic [WORD_W-1:0] rd_word;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_peer, wr_load};
    end
  end

  // Read port, registered data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  assign rd_peer = rd_word[WORD_W-1:LOAD_BITS];
  assign rd_load = rd_word[LOAD_BITS-1:0];

endmodule

[src/lls_ctrl.sv]
// Sequencer: table walk, read-modify-write of loads, list tracking, result register.
module lls_ctrl #(
  parameter int TABLE_DEPTH = 64,
  parameter int LOAD_BITS   = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic [lls_pkg::OP_W-1:0]          op,
  input  logic [lls_pkg::PEER_W-1:0]        peer_id,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [lls_pkg::PEER_W-1:0]        sel_peer,
  output logic                              chosen_valid,
  output logic                              table_overflow,
  output logic                              rd_en,
  output logic [$clog2(TABLE_DEPTH)-1:0]    rd_addr,
  input  logic [lls_pkg::PEER_W-1:0]        rd_peer,
  input  logic [LOAD_BITS-1:0]              rd_load,
  output logic                              wr_en,
  output logic [$clog2(TABLE_DEPTH)-1:0]    wr_addr,
  output logic [lls_pkg::PEER_W-1:0]        wr_peer,
  output logic [LOAD_BITS-1:0]              wr_load
);
  import lls_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [LOAD_BITS-1:0] LOAD_MAX = {LOAD_BITS{1'b1}};
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  // Control state
  lls_state_t          state, state_next;
  logic [CNT_W-1:0]    entry_count, entry_count_next;
  logic                best_found, best_found_next;
  logic                overflow_seen, overflow_seen_next;
  logic [LOAD_BITS-1:0] best_load, best_load_next;
  logic [PEER_W-1:0]   best_peer, best_peer_next;
  logic                result_valid_next;

  // Per-item working registers
  logic [OP_W-1:0]     op_q, op_q_next;
  logic [PEER_W-1:0]   key, key_next;
  logic [CNT_W-1:0]    scan_idx, scan_idx_next;
  logic                cmp_valid, cmp_valid_next;
  logic [IDX_W-1:0]    cmp_idx, cmp_idx_next;
  logic                hit, hit_next;
  logic [IDX_W-1:0]    hit_idx, hit_idx_next;
  logic [LOAD_BITS-1:0] hit_load, hit_load_next;

  // Result payload
  logic [PEER_W-1:0]   sel_peer_next;
  logic                chosen_valid_next;
  logic                table_overflow_next;

  // Offer evaluation
  logic                cand_ok;
  logic [LOAD_BITS-1:0] cand_load;
  logic                issue;

  assign item_stall = (state != ST_IDLE);

  // Next state and datapath
  always_comb begin
    state_next          = state;
    entry_count_next    = entry_count;
    best_found_next     = best_found;
    overflow_seen_next  = overflow_seen;
    best_load_next      = best_load;
    best_peer_next      = best_peer;
    result_valid_next   = result_valid && result_stall;
    op_q_next           = op_q;
    key_next            = key;
    scan_idx_next       = scan_idx;
    cmp_valid_next      = 1'b0;
    cmp_idx_next        = cmp_idx;
    hit_next            = hit;
    hit_idx_next        = hit_idx;
    hit_load_next       = hit_load;
    sel_peer_next       = sel_peer;
    chosen_valid_next   = chosen_valid;
    table_overflow_next = table_overflow;
    cand_ok             = 1'b0;
    cand_load           = '0;
    issue               = 1'b0;
    rd_en               = 1'b0;
    rd_addr             = scan_idx[IDX_W-1:0];
    wr_en               = 1'b0;
    wr_addr             = hit_idx;
    wr_peer             = key;
    wr_load             = '0;

    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          if (op == OP_CLEAR) begin
            entry_count_next = '0;
          end else begin
            op_q_next     = op;
            key_next      = (op == OP_END) ? best_peer : peer_id;
            scan_idx_next = '0;
            state_next    = ST_SCAN;
          end
        end
      end

      // Walk the table: issue one read per cycle, compare the previous one
      ST_SCAN: begin
        issue = (scan_idx < entry_count);
        if (cmp_valid && (rd_peer == key)) begin
          hit_next      = 1'b1;
          hit_idx_next  = cmp_idx;
          hit_load_next = rd_load;
          state_next    = ST_ACT;
        end else if (!cmp_valid && !issue) begin
          hit_next   = 1'b0;
          state_next = ST_ACT;
        end else begin
          rd_en          = issue;
          cmp_valid_next = issue;
          cmp_idx_next   = scan_idx[IDX_W-1:0];
          if (issue) begin
            scan_idx_next = scan_idx + 1'b1;
          end
        end
      end

      // Modify and write back
      ST_ACT: begin
        case (op_q)
          OP_OFFER: begin
            if (hit) begin
              cand_ok   = 1'b1;
              cand_load = hit_load;
            end else if (entry_count < DEPTH_CNT) begin
              wr_en            = 1'b1;
              wr_addr          = entry_count[IDX_W-1:0];
              wr_load          = '0;
              entry_count_next = entry_count + 1'b1;
              cand_ok          = 1'b1;
            end else begin
              overflow_seen_next = 1'b1;
            end
            // first candidate always kept; ties keep the earlier one
            if (cand_ok && (!best_found || (cand_load < best_load))) begin
              best_found_next = 1'b1;
              best_load_next  = cand_load;
              best_peer_next  = key;
            end
            state_next = ST_IDLE;
          end
          OP_RELEASE: begin
            if (hit && (hit_load != '0)) begin
              wr_en   = 1'b1;
              wr_load = hit_load - 1'b1;
            end
            state_next = ST_IDLE;
          end
          OP_END: begin
            // wait for a free result register
            if (!result_valid || !result_stall) begin
              result_valid_next   = 1'b1;
              sel_peer_next       = best_found ? best_peer : '0;
              chosen_valid_next   = best_found;
              table_overflow_next = overflow_seen;
              if (best_found && hit && (hit_load != LOAD_MAX)) begin
                wr_en   = 1'b1;
                wr_load = hit_load + 1'b1;
              end
              best_found_next    = 1'b0;
              overflow_seen_next = 1'b0;
              best_load_next     = LOAD_MAX;
              best_peer_next     = '0;
              state_next         = ST_IDLE;
            end
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      entry_count   <= '0;
      best_found    <= 1'b0;
      overflow_seen <= 1'b0;
      best_load     <= LOAD_MAX;
      best_peer     <= '0;
      result_valid  <= 1'b0;
      cmp_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      entry_count   <= entry_count_next;
      best_found    <= best_found_next;
      overflow_seen <= overflow_seen_next;
      best_load     <= best_load_next;
      best_peer     <= best_peer_next;
      result_valid  <= result_valid_next;
      cmp_valid     <= cmp_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_q           <= op_q_next;
    key            <= key_next;
    scan_idx       <= scan_idx_next;
    cmp_idx        <= cmp_idx_next;
    hit            <= hit_next;
    hit_idx        <= hit_idx_next;
    hit_load       <= hit_load_next;
    sel_peer       <= sel_peer_next;
    chosen_valid   <= chosen_valid_next;
    table_overflow <= table_overflow_next;
  end

endmodule

[src/least_loaded_peer_selector.sv]
// A clear is handled in the idle state; any other item walks the table until its peer is found
// or all filled entries are read (none on an empty table), then acts on the result.
// One item at a time: the next item is accepted when the previous one finishes;
// an end result is registered when its item reaches the action state, and an end
// waits while a stalled result holds the output register.
// Synchronous reset empties the table (fill count to 0) and clears the list state.
module least_loaded_peer_selector #(
  parameter int TABLE_DEPTH = 64,
  parameter int LOAD_BITS   = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic [lls_pkg::OP_W-1:0]    op,
  input  logic [lls_pkg::PEER_W-1:0]  peer_id,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [lls_pkg::PEER_W-1:0]  sel_peer,
  output logic                        chosen_valid,
  output logic                        table_overflow
);
  import lls_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic [PEER_W-1:0]    rd_peer;
  logic [LOAD_BITS-1:0] rd_load;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [PEER_W-1:0]    wr_peer;
  logic [LOAD_BITS-1:0] wr_load;

  lls_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .LOAD_BITS   (LOAD_BITS)
  ) u_table (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_peer (rd_peer),
    .rd_load (rd_load),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_peer (wr_peer),
    .wr_load (wr_load)
  );

  lls_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .LOAD_BITS   (LOAD_BITS)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .op             (op),
    .peer_id        (peer_id),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .sel_peer       (sel_peer),
    .chosen_valid   (chosen_valid),
    .table_overflow (table_overflow),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_peer        (rd_peer),
    .rd_load        (rd_load),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_peer        (wr_peer),
    .wr_load        (wr_load)
  );

endmodule

[src/lls_checker.sv]
// Port-level checks for the least-loaded peer selector, bound to the top level.
module lls_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        item_valid,
  input logic                        item_stall,
  input logic [lls_pkg::OP_W-1:0]    op,
  input logic                        result_valid,
  input logic                        result_stall,
  input logic [lls_pkg::PEER_W-1:0]  sel_peer,
  input logic                        chosen_valid,
  input logic                        table_overflow
);
  import lls_pkg::*;

  // A stalled result beat holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(sel_peer)
      && $stable(chosen_valid) && $stable(table_overflow))
    else $error("stalled result beat changed");

  // An empty list reports peer 0
  a_empty_peer: assert property (@(posedge clk) disable iff (rst)
    result_valid && !chosen_valid |-> sel_peer == '0)
    else $error("no choice but nonzero peer");

  // Any item other than clear needs a table walk, so the input stalls next
  a_busy_after_item: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && (op != OP_CLEAR) |=> item_stall)
    else $error("input not stalled during table walk");

  // A clear completes in the idle state, so the input does not stall for it
  a_clear_fast: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && (op == OP_CLEAR) |=> !item_stall)
    else $error("clear did not finish in one cycle");

  // Nothing is offered out of reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind least_loaded_peer_selector lls_checker u_lls_checker (.*);

[tb/least_loaded_peer_selector_test.sv]
// Self-checking testbench for the least-loaded peer selector: directed table, then random lists.
`timescale 1ns / 1ps

module least_loaded_peer_selector_test;
  import lls_pkg::*;

  localparam int TBL_DEPTH = 64;
  localparam int LOAD_W    = 16;

  // One choice as it leaves the block
  typedef struct packed {
    logic [PEER_W-1:0] peer;
    logic              valid;
    logic              ovf;
  } pick_t;

  // Directed row; typed rows carry their own expected choice
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [PEER_W-1:0] peer;
    logic              typed;
    logic [PEER_W-1:0] exp_peer;
    logic              exp_valid;
    logic              exp_ovf;
  } dir_row_t;

  logic              clk;
  logic              rst          = 1'b1;
  logic              item_valid   = 1'b0;
  logic              item_stall;
  logic [OP_W-1:0]   op           = OP_OFFER;
  logic [PEER_W-1:0] peer_id      = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  logic [PEER_W-1:0] sel_peer;
  logic              chosen_valid;
  logic              table_overflow;

  least_loaded_peer_selector #(
    .TABLE_DEPTH(TBL_DEPTH),
    .LOAD_BITS  (LOAD_W)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .op            (op),
    .peer_id       (peer_id),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .sel_peer      (sel_peer),
    .chosen_valid  (chosen_valid),
    .table_overflow(table_overflow)
  );

  // Directed sequence: empty list, ties, releases, repeats, clear inside a list
  dir_row_t directed_rows [19] = '{
    '{OP_END,     10'd0,    1'b1, 10'd0, 1'b0, 1'b0},  // empty list after reset
    '{OP_OFFER,   10'd0,    1'b0, 10'd0, 1'b0, 1'b0},
    '{OP_OFFER,   10'd1023, 1'b0, 10'd0, 1'b0, 1'b0},
    '{OP_END,     10'd0,    1'b1, 10'd0, 1'b1, 1'b0},  // tie keeps the first
    '{OP_OFFER,   10'd0,    1'b0, 10'd0, 1'b0, 1'b0},
    '{OP_OFFER,   10'd1023, 1'b0, 10'd0, 1'b0, 1'b0},
    '{OP_END,     10'd1023, 1'b0, 10'd0, 1'b0, 1'b0},
    '{OP_RELEASE, 10'd1023, 1'b0, 10'd0, 1'b0, 1'b0},
    '{OP_RELEASE, 10'd1023, 1'b0, 10'd0, 1'b0, 1'b0},  // already at zero
    '{OP_RELEASE, 10'd682,  1'b0, 10'd0, 1'b0, 1'b0},  // unknown peer
    '{OP_OFFER,   10'd1023, 1'b0, 10'd0, 1'b0, 1'b0},
    '{OP_OFFER,   10'd0,    1'b0, 10'd0, 1'b0, 1'b0},
    '{OP_OFFER,   10'd1023, 1'b0, 10'd0, 1'b0, 1'b0},  // repeated candidate
    '{OP_END,     10'd341,  1'b0, 10'd0, 1'b0, 1'b0},
    '{OP_OFFER,   10'd341,  1'b0, 10'd0, 1'b0, 1'b0},
    '{OP_CLEAR,   10'd682,  1'b0, 10'd0, 1'b0, 1'b0},  // clear mid-list
    '{OP_OFFER,   10'd0,    1'b0, 10'd0, 1'b0, 1'b0},
    '{OP_END,     10'd0,    1'b0, 10'd0, 1'b0, 1'b0},  // kept peer gone from table
    '{OP_END,     10'd1023, 1'b1, 10'd0, 1'b0, 1'b0}
  };

  // Predictor state: peer table and current list
  logic [PEER_W-1:0] tbl_peer [TBL_DEPTH];
  logic [LOAD_W-1:0] tbl_load [TBL_DEPTH];
  int                tbl_count;
  logic [LOAD_W-1:0] list_best_load;
  logic [PEER_W-1:0] list_best_peer;
  bit                list_found;
  bit                list_dropped;

  pick_t expected_picks [$];
  int    error_count = 0;
  int    beats_sent  = 0;
  bit    idle_on     = 1'b1;
  int    pool_base   = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void reset_list();
    list_best_load = '1;
    list_best_peer = '0;
    list_found     = 1'b0;
    list_dropped   = 1'b0;
  endfunction

  function automatic int find_peer(logic [PEER_W-1:0] p);
    for (int i = 0; i < tbl_count; i++)
      if (tbl_peer[i] == p) return i;
    return -1;
  endfunction

  // Next state of the selector for one beat; produced is set for a choice
  function automatic void predict_selection(input logic [OP_W-1:0] o,
                                            input logic [PEER_W-1:0] p,
                                            output bit produced, output pick_t pick);
    int                idx;
    logic [LOAD_W-1:0] ld;
    produced = 1'b0;
    pick = '0;
    case (o)
      OP_OFFER: begin
        idx = find_peer(p);
        if (idx >= 0) begin
          ld = tbl_load[idx];
        end else if (tbl_count < TBL_DEPTH) begin
          tbl_peer[tbl_count] = p;
          tbl_load[tbl_count] = '0;
          tbl_count++;
          ld = '0;
        end else begin
          // table full: dropped, does not compete
          list_dropped = 1'b1;
          return;
        end
        if (!list_found || ld < list_best_load) begin
          list_found     = 1'b1;
          list_best_load = ld;
          list_best_peer = p;
        end
      end
      OP_RELEASE: begin
        idx = find_peer(p);
        if (idx >= 0 && tbl_load[idx] != '0) tbl_load[idx]--;
      end
      OP_CLEAR: tbl_count = 0;
      default: begin
        produced   = 1'b1;
        pick.peer  = list_found ? list_best_peer : '0;
        pick.valid = list_found;
        pick.ovf   = list_dropped;
        if (list_found) begin
          idx = find_peer(list_best_peer);
          if (idx >= 0 && tbl_load[idx] != {LOAD_W{1'b1}}) tbl_load[idx]++;
        end
        reset_list();
      end
    endcase
  endfunction

  function automatic logic [PEER_W-1:0] pick_peer();
    if ($urandom_range(0, 9) == 0) return PEER_W'($urandom_range(0, 1023));
    return PEER_W'(pool_base + $urandom_range(0, 79));
  endfunction

  // Drive one item beat and record the choice it should cause
  task automatic send_beat(input logic [OP_W-1:0] o, input logic [PEER_W-1:0] p,
                           input bit typed = 1'b0, input pick_t want = '0);
    bit    stalled;
    bit    produced;
    pick_t pick;
    while (idle_on && $urandom_range(0, 99) < 13) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    op         <= o;
    peer_id    <= p;
    do begin
      @(negedge clk);
      stalled = item_stall;
      @(posedge clk);
    end while (stalled);
    predict_selection(o, p, produced, pick);
    if (produced) expected_picks.push_back(typed ? want : pick);
    beats_sent++;
  endtask

  // Hold the sender off until every pending choice has come back
  task automatic wait_drained();
    item_valid <= 1'b0;
    do @(posedge clk); while (expected_picks.size() != 0);
  endtask

  // Result side: random stall, sample mid-cycle, check after the edge
  initial begin
    bit    hold;
    bit    took;
    pick_t got;
    pick_t want;
    wait (!rst);
    forever begin
      hold = idle_on && ($urandom_range(0, 99) < 13);
      result_stall <= hold;
      @(negedge clk);
      took      = result_valid && !hold;
      got.peer  = sel_peer;
      got.valid = chosen_valid;
      got.ovf   = table_overflow;
      @(posedge clk);
      if (took) begin
        if (expected_picks.size() == 0) begin
          $error("choice beat with none pending: peer %0d", got.peer);
          error_count++;
        end else begin
          want = expected_picks.pop_front();
          if (got.peer !== want.peer) begin
            $error("sel_peer: expected %0d, got %0d", want.peer, got.peer);
            error_count++;
          end
          if (got.valid !== want.valid) begin
            $error("chosen_valid: expected %0d, got %0d", want.valid, got.valid);
            error_count++;
          end
          if (got.ovf !== want.ovf) begin
            $error("table_overflow: expected %0d, got %0d", want.ovf, got.ovf);
            error_count++;
          end
        end
      end
    end
  end

  // Stimulus
  initial begin
    pick_t want;
    int    start;
    int    roll;
    int    n;
    tbl_count = 0;
    reset_list();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      want.peer  = directed_rows[i].exp_peer;
      want.valid = directed_rows[i].exp_valid;
      want.ovf   = directed_rows[i].exp_ovf;
      send_beat(directed_rows[i].op, directed_rows[i].peer, directed_rows[i].typed, want);
    end
    wait_drained();

    // Fill the table past its depth within one list
    send_beat(OP_CLEAR, '0);
    for (int k = 0; k < TBL_DEPTH + 6; k++) send_beat(OP_OFFER, PEER_W'(100 + k));
    send_beat(OP_END, '0);
    send_beat(OP_OFFER, 10'd130);
    send_beat(OP_OFFER, 10'd900);
    send_beat(OP_END, '0);

    // Build up one peer's load, no idling on either side
    idle_on = 1'b0;
    send_beat(OP_CLEAR, '0);
    for (int k = 0; k < 16; k++) begin
      send_beat(OP_OFFER, 10'd7);
      send_beat(OP_END, PEER_W'(k));
    end
    send_beat(OP_OFFER, 10'd7);
    send_beat(OP_OFFER, 10'd8);
    send_beat(OP_END, '0);
    send_beat(OP_RELEASE, 10'd7);
    send_beat(OP_OFFER, 10'd7);
    send_beat(OP_END, '0);
    send_beat(OP_CLEAR, '0);
    idle_on = 1'b1;
    wait_drained();

    // Random lists over a small peer pool so the table fills up
    start = beats_sent;
    pool_base = $urandom_range(0, 1023 - 79);
    while (beats_sent - start < 620) begin
      idle_on = !((beats_sent - start) >= 300 && (beats_sent - start) < 450);
      roll = $urandom_range(0, 99);
      if (roll < 72) begin
        n = $urandom_range(0, 6);
        repeat (n) begin
          if ($urandom_range(0, 99) < 12) send_beat(OP_RELEASE, pick_peer());
          if ($urandom_range(0, 999) < 3) send_beat(OP_CLEAR, PEER_W'($urandom));
          send_beat(OP_OFFER, pick_peer());
        end
        send_beat(OP_END, PEER_W'($urandom));
      end else if (roll < 89) begin
        repeat ($urandom_range(1, 3)) send_beat(OP_RELEASE, pick_peer());
      end else if (roll < 91) begin
        send_beat(OP_CLEAR, PEER_W'($urandom));
        pool_base = $urandom_range(0, 1023 - 79);
      end else if (roll < 97) begin
        // noise: any op with any peer id
        send_beat(OP_W'($urandom_range(0, 3)), PEER_W'($urandom));
      end else begin
        wait_drained();
      end
    end

    wait_drained();
    repeat (TBL_DEPTH + 16) @(posedge clk);
    if (expected_picks.size() != 0) begin
      $error("%0d choices never arrived", expected_picks.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #40_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

[sim.f]
src/lls_pkg.sv
src/lls_table.sv
src/lls_ctrl.sv
src/least_loaded_peer_selector.sv
src/lls_checker.sv
tb/least_loaded_peer_selector_test.sv
